/* rtl/tcg_pkg.sv */
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared widths, codes and control types of the triangle energy gradient block.
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int WORD_W   = 32;
    localparam int EDGE_W   = 33;
    localparam int SUM_W    = 48;
    localparam int WIDE_W   = 168;
    localparam int MUL_B_W  = 67;
    localparam int CNT_W    = 7;
    localparam int ROOT_W   = 64;
    localparam int RAD_W    = 128;
    localparam int Q_W      = 34;
    localparam int DIV_CNT_W = 6;

    localparam int WT_SHIFT   = 34;
    localparam int REST_SHIFT = 66;
    localparam int RAD_SHIFT  = 50;
    localparam int DEN_SHIFT  = 67;

    localparam logic [CNT_W-1:0] NB_EDGE = CNT_W'(33);
    localparam logic [CNT_W-1:0] NB_WT   = CNT_W'(32);
    localparam logic [CNT_W-1:0] NB_S2A  = CNT_W'(67);

    localparam logic [WORD_W-1:0] SCALE_RESET = 32'h0001_0000;

    // area phase ops
    localparam logic [1:0] A_OP_PROD1 = 2'd0;
    localparam logic [1:0] A_OP_PROD2 = 2'd1;
    localparam logic [1:0] A_OP_SCALE = 2'd2;
    localparam logic [1:0] A_OP_RAD   = 2'd3;

    // Dirichlet phase sub-ops
    localparam logic [1:0] D_SUB_SQ_X = 2'd0;
    localparam logic [1:0] D_SUB_SQ_Y = 2'd1;
    localparam logic [1:0] D_SUB_WT   = 2'd2;

    // gradient phase sub-ops
    localparam logic [1:0] G_SUB_AREA = 2'd0;
    localparam logic [1:0] G_SUB_J    = 2'd1;
    localparam logic [1:0] G_SUB_K    = 2'd2;

    localparam logic [1:0] VTX_A    = 2'd0;
    localparam logic [1:0] VTX_B    = 2'd1;
    localparam logic [1:0] VTX_C    = 2'd2;
    localparam logic [2:0] GRAD_LAST = 3'd5;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [CNT_W-1:0] nbits;
    } mac_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_AREA = 8'b0000_0010,
        S_DIR  = 8'b0000_0100,
        S_REST = 8'b0000_1000,
        S_SQRT = 8'b0001_0000,
        S_GRAD = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

endpackage

/* rtl/tcg_if.sv */
// ----------------------------------------------------------------------------
// tcg_if
// Valid/ready channels: triangle words in, result words out, config writes.
// ----------------------------------------------------------------------------
interface tcg_face_if;
    logic                                valid;
    logic                                ready;
    logic signed [tcg_pkg::WORD_W-1:0]   vertex_a_x;
    logic signed [tcg_pkg::WORD_W-1:0]   vertex_a_y;
    logic signed [tcg_pkg::WORD_W-1:0]   vertex_b_x;
    logic signed [tcg_pkg::WORD_W-1:0]   vertex_b_y;
    logic signed [tcg_pkg::WORD_W-1:0]   vertex_c_x;
    logic signed [tcg_pkg::WORD_W-1:0]   vertex_c_y;
    logic signed [tcg_pkg::WORD_W-1:0]   weight_a;
    logic signed [tcg_pkg::WORD_W-1:0]   weight_b;
    logic signed [tcg_pkg::WORD_W-1:0]   weight_c;
    logic        [tcg_pkg::WORD_W-1:0]   rest_term;
    logic                                last_face;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, weight_a, weight_b, weight_c,
               rest_term, last_face,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, weight_a, weight_b, weight_c,
               rest_term, last_face,
        output ready
    );
endinterface

interface tcg_result_if;
    logic                                valid;
    logic                                ready;
    logic        [tcg_pkg::WORD_W-1:0]   face_energy;
    logic signed [tcg_pkg::WORD_W-1:0]   grad_a_x;
    logic signed [tcg_pkg::WORD_W-1:0]   grad_a_y;
    logic signed [tcg_pkg::WORD_W-1:0]   grad_b_x;
    logic signed [tcg_pkg::WORD_W-1:0]   grad_b_y;
    logic signed [tcg_pkg::WORD_W-1:0]   grad_c_x;
    logic signed [tcg_pkg::WORD_W-1:0]   grad_c_y;
    logic        [tcg_pkg::SUM_W-1:0]    total_energy;
    logic                                zero_energy;
    logic                                total_done;

    modport source (
        output valid, face_energy, grad_a_x, grad_a_y, grad_b_x, grad_b_y,
               grad_c_x, grad_c_y, total_energy, zero_energy, total_done,
        input  ready
    );
    modport sink (
        input  valid, face_energy, grad_a_x, grad_a_y, grad_b_x, grad_b_y,
               grad_c_x, grad_c_y, total_energy, zero_energy, total_done,
        output ready
    );
endinterface

interface tcg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tcg_pkg::WORD_W-1:0]        area_scale;

    modport source (output valid, area_scale, input ready);
    modport sink   (input valid, area_scale, output ready);
endinterface

/* rtl/triangle_content_energy_gradient.sv */
// ----------------------------------------------------------------------------
// triangle_content_energy_gradient
// Generalized triangle content, its vertex gradient and a running energy sum.
//
// face is a valid/ready channel: one word per triangle, taken only while the
// block is idle. result returns one word per triangle through an output
// register; the next triangle is taken while that word still waits, but a
// finished word is not replaced until the receiver takes it, so a stalled
// receiver holds the block in its output step.
// cfg writes area_scale at any time the block is idle; cfg.ready is always 1.
// Work per triangle is done by the bit-serial multiply-accumulate unit (31
// passes over 32 to 67 multiplier bits), followed by a 64-bit square root
// and six divisions with 34 quotient bits; when the energy is zero, the
// gradient passes and the divisions are skipped. A new triangle is taken
// only once the last one has left the output step.
// Reset (rst_n low, asynchronous) sets area_scale to 1.0, clears the running
// sum and the output valid. The sum clears after a word marked last_face.
// ----------------------------------------------------------------------------
module triangle_content_energy_gradient (
    input  logic          clk,
    input  logic          rst_n,
    tcg_face_if.sink      face,
    tcg_result_if.source  result,
    tcg_cfg_if.sink       cfg
);
    import tcg_pkg::*;

    state_t                    state_reg;
    logic                      go_reg;
    logic [1:0]                op_reg;
    logic [1:0]                sub_reg;
    logic [1:0]                t_reg;
    logic [2:0]                g_reg;
    logic [WORD_W-1:0]         scale_reg;
    logic [SUM_W-1:0]          energy_sum_reg;
    logic                      out_valid_reg;

    logic signed [EDGE_W-1:0]  ex_reg [3];
    logic signed [EDGE_W-1:0]  ey_reg [3];
    logic signed [WORD_W-1:0]  wt_reg [3];
    logic [WORD_W-1:0]         rest_reg;
    logic                      last_reg;
    logic signed [MUL_B_W-1:0] s2a_reg;
    logic signed [WIDE_W-1:0]  cs_reg;
    logic signed [WIDE_W-1:0]  rad_reg;
    logic [ROOT_W-1:0]         eq_reg;
    logic signed [WORD_W-1:0]  grad_reg [6];

    logic [WORD_W-1:0]         fe_out_reg;
    logic signed [WORD_W-1:0]  grad_out_reg [6];
    logic [SUM_W-1:0]          total_out_reg;
    logic                      zero_out_reg;
    logic                      done_out_reg;

    mac_cmd_t                  mac_cmd;
    logic signed [WIDE_W-1:0]  mac_init;
    logic signed [WIDE_W-1:0]  mac_a;
    logic signed [MUL_B_W-1:0] mac_b;
    logic signed [WIDE_W-1:0]  mac_acc;
    unit_stat_t                mac_stat;
    logic [RAD_W-1:0]          sq_in;
    logic [ROOT_W-1:0]         sq_root;
    unit_stat_t                sq_stat;
    logic signed [WORD_W-1:0]  div_quo;
    unit_stat_t                div_stat;

    logic                      accept;
    logic                      out_load;
    logic [1:0]                gt, gj, gk;
    logic                      gy;
    logic                      zero_e;
    logic [WORD_W-1:0]         fe;
    logic [SUM_W:0]            total_wide;
    logic [SUM_W-1:0]          total;

    assign face.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign accept     = face.valid && face.ready;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        gt = g_reg[2:1];
        gy = g_reg[0];
        gj = (gt == VTX_C) ? VTX_A : gt + 2'd1;
        gk = (gt == VTX_A) ? VTX_C : gt - 2'd1;
    end

    always_comb
    begin
        zero_e     = (eq_reg == '0);
        fe         = (eq_reg[ROOT_W-1:WORD_W] != '0) ? '1 : eq_reg[WORD_W-1:0];
        total_wide = {1'b0, energy_sum_reg} + (SUM_W+1)'(fe);
        total      = total_wide[SUM_W] ? '1 : total_wide[SUM_W-1:0];
        sq_in      = rad_reg[WIDE_W-1] ? '0 : RAD_W'(rad_reg[WIDE_W-1:RAD_SHIFT]);
    end

    // multiply-accumulate operand select
    always_comb
    begin
        mac_init = '0;
        mac_a    = '0;
        mac_b    = '0;
        mac_cmd.nbits = NB_EDGE;
        mac_cmd.neg   = 1'b0;
        mac_cmd.start = go_reg &&
                        ((state_reg == S_AREA) || (state_reg == S_DIR) ||
                         (state_reg == S_GRAD));
        unique case (state_reg)
            S_AREA:
            begin
                unique case (op_reg)
                    A_OP_PROD1:
                    begin
                        mac_a = WIDE_W'(ey_reg[VTX_C]);
                        mac_b = MUL_B_W'(ex_reg[VTX_B]);
                    end
                    A_OP_PROD2:
                    begin
                        mac_init    = mac_acc;
                        mac_a       = WIDE_W'(ex_reg[VTX_C]);
                        mac_b       = MUL_B_W'(ey_reg[VTX_B]);
                        mac_cmd.neg = 1'b1;
                    end
                    A_OP_SCALE:
                    begin
                        mac_a = WIDE_W'(s2a_reg);
                        mac_b = MUL_B_W'({1'b0, scale_reg});
                    end
                    A_OP_RAD:
                    begin
                        mac_a         = cs_reg;
                        mac_b         = s2a_reg;
                        mac_cmd.nbits = NB_S2A;
                    end
                endcase
            end
            S_DIR:
            begin
                unique case (sub_reg)
                    D_SUB_SQ_X:
                    begin
                        mac_a = WIDE_W'(ex_reg[t_reg]);
                        mac_b = MUL_B_W'(ex_reg[t_reg]);
                    end
                    D_SUB_SQ_Y:
                    begin
                        mac_init = mac_acc;
                        mac_a    = WIDE_W'(ey_reg[t_reg]);
                        mac_b    = MUL_B_W'(ey_reg[t_reg]);
                    end
                    default:
                    begin
                        mac_init      = rad_reg;
                        mac_a         = mac_acc <<< WT_SHIFT;
                        mac_b         = MUL_B_W'(wt_reg[t_reg]);
                        mac_cmd.nbits = NB_WT;
                    end
                endcase
            end
            S_GRAD:
            begin
                unique case (sub_reg)
                    G_SUB_AREA:
                    begin
                        mac_a       = cs_reg;
                        mac_b       = gy ? MUL_B_W'(ex_reg[gt]) : MUL_B_W'(ey_reg[gt]);
                        mac_cmd.neg = !gy;
                    end
                    G_SUB_J:
                    begin
                        mac_init = mac_acc;
                        mac_a    = WIDE_W'(wt_reg[gj]) <<< WT_SHIFT;
                        mac_b    = gy ? MUL_B_W'(ey_reg[gj]) : MUL_B_W'(ex_reg[gj]);
                    end
                    default:
                    begin
                        mac_init    = mac_acc;
                        mac_a       = WIDE_W'(wt_reg[gk]) <<< WT_SHIFT;
                        mac_b       = gy ? MUL_B_W'(ey_reg[gk]) : MUL_B_W'(ex_reg[gk]);
                        mac_cmd.neg = 1'b1;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    tcg_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mac_cmd),
        .acc_init (mac_init),
        .a_in     (mac_a),
        .b_in     (mac_b),
        .acc      (mac_acc),
        .stat     (mac_stat)
    );

    tcg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg && (state_reg == S_SQRT)),
        .x_in  (sq_in),
        .root  (sq_root),
        .stat  (sq_stat)
    );

    tcg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg && (state_reg == S_DIV)),
        .num   (mac_acc),
        .eq    (eq_reg),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            go_reg         <= 1'b0;
            op_reg         <= '0;
            sub_reg        <= '0;
            t_reg          <= '0;
            g_reg          <= '0;
            scale_reg      <= SCALE_RESET;
            energy_sum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (cfg.valid)
            begin
                scale_reg <= cfg.area_scale;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_AREA;
                        op_reg    <= A_OP_PROD1;
                        go_reg    <= 1'b1;
                    end
                end
                S_AREA:
                begin
                    if (mac_stat.done)
                    begin
                        go_reg <= 1'b1;
                        if (op_reg == A_OP_RAD)
                        begin
                            state_reg <= S_DIR;
                            t_reg     <= VTX_A;
                            sub_reg   <= D_SUB_SQ_X;
                        end
                        else
                        begin
                            op_reg <= op_reg + 2'd1;
                        end
                    end
                end
                S_DIR:
                begin
                    if (mac_stat.done)
                    begin
                        if (sub_reg == D_SUB_WT)
                        begin
                            sub_reg <= D_SUB_SQ_X;
                            if (t_reg == VTX_C)
                            begin
                                state_reg <= S_REST;
                            end
                            else
                            begin
                                t_reg  <= t_reg + 2'd1;
                                go_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 2'd1;
                            go_reg  <= 1'b1;
                        end
                    end
                end
                S_REST:
                begin
                    state_reg <= S_SQRT;
                    go_reg    <= 1'b1;
                end
                S_SQRT:
                begin
                    if (sq_stat.done)
                    begin
                        g_reg   <= '0;
                        sub_reg <= G_SUB_AREA;
                        if (sq_root == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_GRAD;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                S_GRAD:
                begin
                    if (mac_stat.done)
                    begin
                        go_reg <= 1'b1;
                        if (sub_reg == G_SUB_K)
                        begin
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 2'd1;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        sub_reg <= G_SUB_AREA;
                        if (g_reg == GRAD_LAST)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            g_reg     <= g_reg + 3'd1;
                            state_reg <= S_GRAD;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg      <= S_IDLE;
                        energy_sum_reg <= last_reg ? '0 : total;
                    end
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_reg[VTX_A] <= EDGE_W'(face.vertex_c_x) - EDGE_W'(face.vertex_b_x);
            ey_reg[VTX_A] <= EDGE_W'(face.vertex_c_y) - EDGE_W'(face.vertex_b_y);
            ex_reg[VTX_B] <= EDGE_W'(face.vertex_a_x) - EDGE_W'(face.vertex_c_x);
            ey_reg[VTX_B] <= EDGE_W'(face.vertex_a_y) - EDGE_W'(face.vertex_c_y);
            ex_reg[VTX_C] <= EDGE_W'(face.vertex_b_x) - EDGE_W'(face.vertex_a_x);
            ey_reg[VTX_C] <= EDGE_W'(face.vertex_b_y) - EDGE_W'(face.vertex_a_y);
            wt_reg[VTX_A] <= face.weight_a;
            wt_reg[VTX_B] <= face.weight_b;
            wt_reg[VTX_C] <= face.weight_c;
            rest_reg      <= face.rest_term;
            last_reg      <= face.last_face;
        end
        if ((state_reg == S_AREA) && mac_stat.done)
        begin
            unique case (op_reg)
                A_OP_PROD1: begin end
                A_OP_PROD2: s2a_reg <= mac_acc[MUL_B_W-1:0];
                A_OP_SCALE: cs_reg  <= mac_acc;
                A_OP_RAD:   rad_reg <= mac_acc;
            endcase
        end
        if ((state_reg == S_DIR) && mac_stat.done && (sub_reg == D_SUB_WT))
        begin
            rad_reg <= mac_acc;
        end
        if (state_reg == S_REST)
        begin
            rad_reg <= rad_reg + (WIDE_W'({1'b0, rest_reg}) <<< REST_SHIFT);
        end
        if ((state_reg == S_SQRT) && sq_stat.done)
        begin
            eq_reg <= sq_root;
        end
        if ((state_reg == S_DIV) && div_stat.done)
        begin
            grad_reg[g_reg] <= div_quo;
        end
        if (out_load)
        begin
            fe_out_reg    <= fe;
            total_out_reg <= total;
            zero_out_reg  <= zero_e;
            done_out_reg  <= last_reg;
            for (int i = 0; i < 6; i++)
            begin
                grad_out_reg[i] <= zero_e ? '0 : grad_reg[i];
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.face_energy  = fe_out_reg;
    assign result.grad_a_x     = grad_out_reg[0];
    assign result.grad_a_y     = grad_out_reg[1];
    assign result.grad_b_x     = grad_out_reg[2];
    assign result.grad_b_y     = grad_out_reg[3];
    assign result.grad_c_x     = grad_out_reg[4];
    assign result.grad_c_y     = grad_out_reg[5];
    assign result.total_energy = total_out_reg;
    assign result.zero_energy  = zero_out_reg;
    assign result.total_done   = done_out_reg;

    // idle means every unit is quiet
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        face.ready |-> !mac_stat.busy && !sq_stat.busy && !div_stat.busy)
        else $error("unit busy while idle");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !face.ready)
        else $error("second word taken during work");

    a_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_energy |->
            (result.grad_a_x == 0) && (result.grad_a_y == 0) &&
            (result.grad_b_x == 0) && (result.grad_b_y == 0) &&
            (result.grad_c_x == 0) && (result.grad_c_y == 0) &&
            (result.face_energy == 0))
        else $error("zero energy with nonzero result");

endmodule

/* rtl/tcg_mac.sv */
// ----------------------------------------------------------------------------
// tcg_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tcg_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tcg_pkg::mac_cmd_t                    cmd,
    input  logic signed [tcg_pkg::WIDE_W-1:0]    acc_init,
    input  logic signed [tcg_pkg::WIDE_W-1:0]    a_in,
    input  logic signed [tcg_pkg::MUL_B_W-1:0]   b_in,
    output logic signed [tcg_pkg::WIDE_W-1:0]    acc,
    output tcg_pkg::unit_stat_t                  stat
);
    import tcg_pkg::*;

    logic signed [WIDE_W-1:0]  acc_reg, acc_next;
    logic signed [WIDE_W-1:0]  a_reg;
    logic signed [MUL_B_W-1:0] b_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      last;
    logic signed [WIDE_W-1:0]  term;

    // top multiplier bit carries negative weight
    always_comb
    begin
        last = (cnt_reg == CNT_W'(1));
        term = b_reg[0] ? a_reg : '0;
        if (last ^ neg_reg)
        begin
            acc_next = acc_reg - term;
        end
        else
        begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= acc_init;
            a_reg   <= a_in;
            b_reg   <= b_in;
            neg_reg <= cmd.neg;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            a_reg   <= a_reg <<< 1;
            b_reg   <= b_reg >>> 1;
        end
    end

    assign acc       = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/tcg_sqrt.sv */
// ----------------------------------------------------------------------------
// tcg_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tcg_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tcg_pkg::RAD_W-1:0]     x_in,
    output logic [tcg_pkg::ROOT_W-1:0]    root,
    output tcg_pkg::unit_stat_t           stat
);
    import tcg_pkg::*;

    logic [RAD_W-1:0]    xs_reg;
    logic [ROOT_W+3:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ROOT_W+3:0]   rem_sh;
    logic [ROOT_W+3:0]   trial;
    logic                ge;

    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W+1:0], xs_reg[RAD_W-1:RAD_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xs_reg   <= x_in;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            xs_reg   <= {xs_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/tcg_div.sv */
// ----------------------------------------------------------------------------
// tcg_div
// Restoring divider: signed numerator by energy, truncated, saturated to 32b.
// ----------------------------------------------------------------------------
module tcg_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tcg_pkg::WIDE_W-1:0]   num,
    input  logic [tcg_pkg::ROOT_W-1:0]          eq,
    output logic signed [tcg_pkg::WORD_W-1:0]   quo,
    output tcg_pkg::unit_stat_t                 stat
);
    import tcg_pkg::*;

    logic [WIDE_W-1:0]    mag_reg;
    logic [WIDE_W-1:0]    d_reg;
    logic [Q_W-1:0]       q_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 ge;

    assign ge = (mag_reg >= d_reg);

    // quotient bit 33 set means the true quotient is far out of range
    always_comb
    begin
        if (neg_reg)
        begin
            if ((q_reg[Q_W-1:WORD_W] != '0) || (q_reg[WORD_W-1:0] > 32'h8000_0000))
            begin
                quo = 32'sh8000_0000;
            end
            else
            begin
                quo = -$signed(q_reg[WORD_W-1:0]);
            end
        end
        else
        begin
            if (q_reg[Q_W-1:WORD_W-1] != '0)
            begin
                quo = 32'sh7FFF_FFFF;
            end
            else
            begin
                quo = $signed(q_reg[WORD_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= num[WIDE_W-1] ? unsigned'(-num) : unsigned'(num);
            neg_reg <= num[WIDE_W-1];
            d_reg   <= WIDE_W'(eq) << DEN_SHIFT;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                mag_reg <= mag_reg - d_reg;
            end
            q_reg <= {q_reg[Q_W-2:0], ge};
            d_reg <= d_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
